// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers for the design files.
// They expect signals named clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)

`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: design/sfcs_pkg.sv
// ----------------------------------------------------------------------------
// SPI flash command sequencer package
// Field widths, request and phase codes, flash opcodes and beat structures.
// ----------------------------------------------------------------------------
package sfcs_pkg;

    localparam int REQ_W    = 3;
    localparam int SECTOR_W = 6;
    localparam int SIZE_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 18;
    localparam int TXLEN_W  = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_READ  = 3'd0,
        REQ_WRITE = 3'd1,
        REQ_DONE  = 3'd2,
        REQ_STAT  = 3'd3,
        REQ_STAT1 = 3'd4
    } req_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_READ   = 3'd1,
        PH_UNLOCK = 3'd2,
        PH_ERASE  = 3'd3,
        PH_WRITE  = 3'd4,
        PH_STAT   = 3'd5,
        PH_STAT1  = 3'd6
    } phase_t;

    localparam logic [BYTE_W-1:0] OP_WRSR  = 8'h01;
    localparam logic [BYTE_W-1:0] OP_READ  = 8'h03;
    localparam logic [BYTE_W-1:0] OP_WRDI  = 8'h04;
    localparam logic [BYTE_W-1:0] OP_RDSR  = 8'h05;
    localparam logic [BYTE_W-1:0] OP_WREN  = 8'h06;
    localparam logic [BYTE_W-1:0] OP_SE    = 8'h20;
    localparam logic [BYTE_W-1:0] OP_RDSR1 = 8'h35;
    localparam logic [BYTE_W-1:0] OP_EWSR  = 8'h50;
    localparam logic [BYTE_W-1:0] OP_AAI   = 8'hAD;

    localparam logic [BYTE_W-1:0] SR_BUSY    = 8'h01;
    localparam logic [BYTE_W-1:0] SR_BP_MASK = 8'h0C;

    localparam logic [TXLEN_W-1:0] TX_CMD     = 3'd1;
    localparam logic [TXLEN_W-1:0] TX_CMD_BYTE = 3'd2;
    localparam logic [TXLEN_W-1:0] TX_CMD_ADDR = 3'd4;
    localparam logic [TXLEN_W-1:0] TX_AAI     = 3'd6;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [SECTOR_W-1:0] sector;
        logic [SIZE_W-1:0]   transfer_size;
        logic [BYTE_W-1:0]   first_byte;
        logic [BYTE_W-1:0]   second_byte;
        logic [BYTE_W-1:0]   status_byte;
    } req_t;

    typedef struct packed {
        logic                accepted;
        logic                xfer_start;
        logic [BYTE_W-1:0]   opcode;
        logic [ADDR_W-1:0]   address;
        logic [TXLEN_W-1:0]  tx_len;
        logic [BYTE_W-1:0]   payload_a;
        logic [BYTE_W-1:0]   payload_b;
        logic [SIZE_W-1:0]   rx_len;
        logic                wp_asserted;
        logic                done_res;
        logic                done_ok;
        logic [BYTE_W-1:0]   status_value;
    } rsp_t;

endpackage

// File: design/sfcs_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one event beat into the sequencer.
// ----------------------------------------------------------------------------
interface sfcs_req_if;

    logic                             valid;
    logic                             ready;
    logic [sfcs_pkg::REQ_W-1:0]       req_type;
    logic [sfcs_pkg::SECTOR_W-1:0]    sector;
    logic [sfcs_pkg::SIZE_W-1:0]      transfer_size;
    logic [sfcs_pkg::BYTE_W-1:0]      first_byte;
    logic [sfcs_pkg::BYTE_W-1:0]      second_byte;
    logic [sfcs_pkg::BYTE_W-1:0]      status_byte;

    modport source (
        output valid, req_type, sector, transfer_size, first_byte, second_byte,
               status_byte,
        input  ready
    );

    modport sink (
        input  valid, req_type, sector, transfer_size, first_byte, second_byte,
               status_byte,
        output ready
    );

endinterface

// File: design/sfcs_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result beat out of the sequencer.
// ----------------------------------------------------------------------------
interface sfcs_rsp_if;

    logic                             valid;
    logic                             ready;
    logic                             accepted;
    logic                             xfer_start;
    logic [sfcs_pkg::BYTE_W-1:0]      opcode;
    logic [sfcs_pkg::ADDR_W-1:0]      address;
    logic [sfcs_pkg::TXLEN_W-1:0]     tx_len;
    logic [sfcs_pkg::BYTE_W-1:0]      payload_a;
    logic [sfcs_pkg::BYTE_W-1:0]      payload_b;
    logic [sfcs_pkg::SIZE_W-1:0]      rx_len;
    logic                             wp_asserted;
    logic                             done_res;
    logic                             done_ok;
    logic [sfcs_pkg::BYTE_W-1:0]      status_value;

    modport source (
        output valid, accepted, xfer_start, opcode, address, tx_len, payload_a,
               payload_b, rx_len, wp_asserted, done_res, done_ok, status_value,
        input  ready
    );

    modport sink (
        input  valid, accepted, xfer_start, opcode, address, tx_len, payload_a,
               payload_b, rx_len, wp_asserted, done_res, done_ok, status_value,
        output ready
    );

endinterface

// File: design/sfcs_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Captures one request beat and holds it until the engine consumes it.
// ----------------------------------------------------------------------------
module sfcs_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    sfcs_req_if.sink          req,
    input  logic              advance,
    output logic              item_valid,
    output sfcs_pkg::req_t    item
);

    logic           valid_reg;
    logic           valid_next;
    sfcs_pkg::req_t item_reg;

    assign req.ready  = !valid_reg || advance;
    assign valid_next = req.valid || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg <= '{req_type:      req.req_type,
                          sector:        req.sector,
                          transfer_size: req.transfer_size,
                          first_byte:    req.first_byte,
                          second_byte:   req.second_byte,
                          status_byte:   req.status_byte};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: design/sfcs_engine.sv
// ----------------------------------------------------------------------------
// Sequencer engine
// Holds the operation state and computes the next frame for one event.
// ----------------------------------------------------------------------------
module sfcs_engine #(
    parameter int unsigned SECTOR_BYTES = 4096,
    parameter int unsigned FLASH_BYTES  = 262144
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  sfcs_pkg::req_t    item,
    output sfcs_pkg::rsp_t    rsp_next
);

    localparam int unsigned NUM_SECTORS = FLASH_BYTES / SECTOR_BYTES;

    sfcs_pkg::phase_t                   phase_reg;
    sfcs_pkg::phase_t                   phase_next;
    logic [sfcs_pkg::BYTE_W-1:0]        last_opcode_reg;
    logic [sfcs_pkg::BYTE_W-1:0]        last_opcode_next;
    logic                               unlocked_reg;
    logic                               unlocked_next;
    logic [sfcs_pkg::SECTOR_W-1:0]      target_sector_reg;
    logic [sfcs_pkg::SECTOR_W-1:0]      target_sector_next;
    logic [sfcs_pkg::BYTE_W-1:0]        held_bytes_reg [2];
    logic                               protect_pin_reg;
    logic                               protect_pin_next;

    logic                               idle;
    logic                               sec_ok;
    logic                               size_ok;
    logic                               sr_busy;
    logic                               bp_clear;
    logic                               hold_write;

    function automatic logic [sfcs_pkg::ADDR_W-1:0] sector_addr(
        input logic [sfcs_pkg::SECTOR_W-1:0] s
    );
        logic [31:0] full;
        full = 32'(s) * 32'(SECTOR_BYTES);
        return full[sfcs_pkg::ADDR_W-1:0];
    endfunction

    assign idle     = (phase_reg == sfcs_pkg::PH_IDLE);
    assign sec_ok   = (32'(item.sector) < NUM_SECTORS);
    assign size_ok  = (32'(item.transfer_size) <= SECTOR_BYTES);
    assign sr_busy  = ((item.status_byte & sfcs_pkg::SR_BUSY) != '0);
    assign bp_clear = ((item.status_byte & sfcs_pkg::SR_BP_MASK) == '0);

    always_comb
    begin
        phase_next = phase_reg;
        case (sfcs_pkg::req_kind_t'(item.req_type))
            sfcs_pkg::REQ_READ:
            begin
                if (idle && sec_ok)
                begin
                    phase_next = sfcs_pkg::PH_READ;
                end
            end
            sfcs_pkg::REQ_WRITE:
            begin
                if (idle && sec_ok && size_ok)
                begin
                    phase_next = unlocked_reg ? sfcs_pkg::PH_ERASE : sfcs_pkg::PH_UNLOCK;
                end
            end
            sfcs_pkg::REQ_DONE:
            begin
                case (phase_reg)
                    sfcs_pkg::PH_READ:
                    begin
                        phase_next = sfcs_pkg::PH_IDLE;
                    end
                    sfcs_pkg::PH_UNLOCK:
                    begin
                        if (last_opcode_reg != sfcs_pkg::OP_EWSR &&
                            last_opcode_reg != sfcs_pkg::OP_WRSR)
                        begin
                            phase_next = bp_clear ? sfcs_pkg::PH_ERASE : sfcs_pkg::PH_IDLE;
                        end
                    end
                    sfcs_pkg::PH_ERASE:
                    begin
                        if (last_opcode_reg == sfcs_pkg::OP_RDSR)
                        begin
                            if (!sr_busy)
                            begin
                                phase_next = sfcs_pkg::PH_WRITE;
                            end
                        end
                        else if (last_opcode_reg != sfcs_pkg::OP_WREN &&
                                 last_opcode_reg != sfcs_pkg::OP_SE)
                        begin
                            phase_next = sfcs_pkg::PH_IDLE;
                        end
                    end
                    sfcs_pkg::PH_WRITE:
                    begin
                        if (last_opcode_reg != sfcs_pkg::OP_WREN &&
                            last_opcode_reg != sfcs_pkg::OP_AAI &&
                            last_opcode_reg != sfcs_pkg::OP_RDSR)
                        begin
                            phase_next = sfcs_pkg::PH_IDLE;
                        end
                    end
                    sfcs_pkg::PH_STAT, sfcs_pkg::PH_STAT1:
                    begin
                        phase_next = sfcs_pkg::PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            sfcs_pkg::REQ_STAT:
            begin
                if (idle)
                begin
                    phase_next = sfcs_pkg::PH_STAT;
                end
            end
            sfcs_pkg::REQ_STAT1:
            begin
                if (idle)
                begin
                    phase_next = sfcs_pkg::PH_STAT1;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        rsp_next           = '0;
        unlocked_next      = unlocked_reg;
        target_sector_next = target_sector_reg;
        protect_pin_next   = protect_pin_reg;
        hold_write         = 1'b0;
        case (sfcs_pkg::req_kind_t'(item.req_type))
            sfcs_pkg::REQ_READ:
            begin
                if (idle && sec_ok)
                begin
                    rsp_next.accepted   = 1'b1;
                    rsp_next.xfer_start = 1'b1;
                    rsp_next.opcode     = sfcs_pkg::OP_READ;
                    rsp_next.address    = sector_addr(item.sector);
                    rsp_next.tx_len     = sfcs_pkg::TX_CMD_ADDR;
                    rsp_next.rx_len     = item.transfer_size;
                end
            end
            sfcs_pkg::REQ_WRITE:
            begin
                if (idle && sec_ok && size_ok)
                begin
                    rsp_next.accepted   = 1'b1;
                    rsp_next.xfer_start = 1'b1;
                    rsp_next.tx_len     = sfcs_pkg::TX_CMD;
                    target_sector_next  = item.sector;
                    hold_write          = 1'b1;
                    if (unlocked_reg)
                    begin
                        rsp_next.opcode = sfcs_pkg::OP_WREN;
                    end
                    else
                    begin
                        rsp_next.opcode  = sfcs_pkg::OP_EWSR;
                        protect_pin_next = 1'b0;
                    end
                end
            end
            sfcs_pkg::REQ_DONE:
            begin
                case (phase_reg)
                    sfcs_pkg::PH_READ:
                    begin
                        rsp_next.done_res = 1'b1;
                        rsp_next.done_ok  = 1'b1;
                    end
                    sfcs_pkg::PH_UNLOCK:
                    begin
                        if (last_opcode_reg == sfcs_pkg::OP_EWSR)
                        begin
                            rsp_next.xfer_start = 1'b1;
                            rsp_next.opcode     = sfcs_pkg::OP_WRSR;
                            rsp_next.tx_len     = sfcs_pkg::TX_CMD_BYTE;
                        end
                        else if (last_opcode_reg == sfcs_pkg::OP_WRSR)
                        begin
                            rsp_next.xfer_start = 1'b1;
                            rsp_next.opcode     = sfcs_pkg::OP_RDSR;
                            rsp_next.tx_len     = sfcs_pkg::TX_CMD;
                            rsp_next.rx_len     = 16'd1;
                        end
                        else
                        begin
                            protect_pin_next = 1'b1;
                            if (bp_clear)
                            begin
                                unlocked_next       = 1'b1;
                                rsp_next.xfer_start = 1'b1;
                                rsp_next.opcode     = sfcs_pkg::OP_WREN;
                                rsp_next.tx_len     = sfcs_pkg::TX_CMD;
                            end
                            else
                            begin
                                rsp_next.done_res = 1'b1;
                            end
                        end
                    end
                    sfcs_pkg::PH_ERASE:
                    begin
                        if (last_opcode_reg == sfcs_pkg::OP_WREN)
                        begin
                            rsp_next.xfer_start = 1'b1;
                            rsp_next.opcode     = sfcs_pkg::OP_SE;
                            rsp_next.address    = sector_addr(target_sector_reg);
                            rsp_next.tx_len     = sfcs_pkg::TX_CMD_ADDR;
                        end
                        else if (last_opcode_reg == sfcs_pkg::OP_SE ||
                                 (last_opcode_reg == sfcs_pkg::OP_RDSR && sr_busy))
                        begin
                            rsp_next.xfer_start = 1'b1;
                            rsp_next.opcode     = sfcs_pkg::OP_RDSR;
                            rsp_next.tx_len     = sfcs_pkg::TX_CMD;
                            rsp_next.rx_len     = 16'd1;
                        end
                        else if (last_opcode_reg == sfcs_pkg::OP_RDSR)
                        begin
                            rsp_next.xfer_start = 1'b1;
                            rsp_next.opcode     = sfcs_pkg::OP_WREN;
                            rsp_next.tx_len     = sfcs_pkg::TX_CMD;
                        end
                        else
                        begin
                            rsp_next.done_res = 1'b1;
                        end
                    end
                    sfcs_pkg::PH_WRITE:
                    begin
                        if (last_opcode_reg == sfcs_pkg::OP_WREN)
                        begin
                            rsp_next.xfer_start = 1'b1;
                            rsp_next.opcode     = sfcs_pkg::OP_AAI;
                            rsp_next.address    = sector_addr(target_sector_reg);
                            rsp_next.tx_len     = sfcs_pkg::TX_AAI;
                            rsp_next.payload_a  = held_bytes_reg[0];
                            rsp_next.payload_b  = held_bytes_reg[1];
                        end
                        else if (last_opcode_reg == sfcs_pkg::OP_AAI ||
                                 (last_opcode_reg == sfcs_pkg::OP_RDSR && sr_busy))
                        begin
                            rsp_next.xfer_start = 1'b1;
                            rsp_next.opcode     = sfcs_pkg::OP_RDSR;
                            rsp_next.tx_len     = sfcs_pkg::TX_CMD;
                            rsp_next.rx_len     = 16'd1;
                        end
                        else if (last_opcode_reg == sfcs_pkg::OP_RDSR)
                        begin
                            rsp_next.xfer_start = 1'b1;
                            rsp_next.opcode     = sfcs_pkg::OP_WRDI;
                            rsp_next.tx_len     = sfcs_pkg::TX_CMD;
                        end
                        else if (last_opcode_reg == sfcs_pkg::OP_WRDI)
                        begin
                            rsp_next.done_res = 1'b1;
                            rsp_next.done_ok  = 1'b1;
                        end
                        else
                        begin
                            rsp_next.done_res = 1'b1;
                        end
                    end
                    sfcs_pkg::PH_STAT, sfcs_pkg::PH_STAT1:
                    begin
                        rsp_next.status_value = item.status_byte;
                    end
                    default:
                    begin
                        rsp_next.xfer_start = 1'b0;
                    end
                endcase
            end
            sfcs_pkg::REQ_STAT, sfcs_pkg::REQ_STAT1:
            begin
                if (idle)
                begin
                    rsp_next.accepted   = 1'b1;
                    rsp_next.xfer_start = 1'b1;
                    rsp_next.opcode     = (item.req_type == sfcs_pkg::REQ_STAT) ?
                                          sfcs_pkg::OP_RDSR : sfcs_pkg::OP_RDSR1;
                    rsp_next.tx_len     = sfcs_pkg::TX_CMD;
                    rsp_next.rx_len     = 16'd1;
                end
            end
            default:
            begin
                rsp_next.accepted = 1'b0;
            end
        endcase
        rsp_next.wp_asserted = protect_pin_next;
        last_opcode_next     = rsp_next.xfer_start ? rsp_next.opcode : last_opcode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= sfcs_pkg::PH_IDLE;
            last_opcode_reg   <= '0;
            unlocked_reg      <= 1'b0;
            target_sector_reg <= '0;
            protect_pin_reg   <= 1'b1;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            last_opcode_reg   <= last_opcode_next;
            unlocked_reg      <= unlocked_next;
            target_sector_reg <= target_sector_next;
            protect_pin_reg   <= protect_pin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && hold_write)
        begin
            held_bytes_reg[0] <= item.first_byte;
            held_bytes_reg[1] <= item.second_byte;
        end
    end

endmodule

// File: design/sfcs_out_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module sfcs_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  sfcs_pkg::rsp_t    rsp_next,
    output logic              room,
    sfcs_rsp_if.source        rsp
);

    logic           valid_reg;
    logic           valid_next;
    sfcs_pkg::rsp_t rsp_reg;

    assign room       = !valid_reg || rsp.ready;
    assign valid_next = load || (valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid        = valid_reg;
    assign rsp.accepted     = rsp_reg.accepted;
    assign rsp.xfer_start   = rsp_reg.xfer_start;
    assign rsp.opcode       = rsp_reg.opcode;
    assign rsp.address      = rsp_reg.address;
    assign rsp.tx_len       = rsp_reg.tx_len;
    assign rsp.payload_a    = rsp_reg.payload_a;
    assign rsp.payload_b    = rsp_reg.payload_b;
    assign rsp.rx_len       = rsp_reg.rx_len;
    assign rsp.wp_asserted  = rsp_reg.wp_asserted;
    assign rsp.done_res     = rsp_reg.done_res;
    assign rsp.done_ok      = rsp_reg.done_ok;
    assign rsp.status_value = rsp_reg.status_value;

endmodule

// File: design/spi_flash_command_sequencer.sv
// ----------------------------------------------------------------------------
// SPI flash command sequencer
// Turns request and transfer-complete events into the next serial-flash
// command frame, with unlock, sector erase and two-byte program sequences.
// ----------------------------------------------------------------------------
// Channel   Direction   Beat contents
// req       in          event type, sector, size, two data bytes, status byte
// rsp       out         accept flag, frame fields, protect level, done, status
//
// Every event gives exactly one result beat: the input register captures the
// event, and the result register loads the engine's result once there is room.
// One beat per cycle is sustained while rsp.ready stays high: the input register
// feeds the engine and the result register in the same cycle the state registers update.
// After rst_n the block is idle with write protect asserted.
// A stalled result holds the input register; req.ready drops once both are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spi_flash_command_sequencer #(
    parameter int unsigned SECTOR_BYTES = 4096,
    parameter int unsigned FLASH_BYTES  = 262144
) (
    input  logic        clk,
    input  logic        rst_n,
    sfcs_req_if.sink    req,
    sfcs_rsp_if.source  rsp
);

    logic           item_valid;
    logic           room;
    logic           advance;
    sfcs_pkg::req_t item;
    sfcs_pkg::rsp_t rsp_next;

    assign advance = item_valid && room;

    sfcs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sfcs_engine #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .FLASH_BYTES  (FLASH_BYTES)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .item     (item),
        .rsp_next (rsp_next)
    );

    sfcs_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .rsp_next (rsp_next),
        .room     (room),
        .rsp      (rsp)
    );

    `ASSERT_PROP(a_full_stall, item_valid && rsp.valid && !rsp.ready |-> !req.ready, "input taken while both stages are full")
    `ASSERT_PROP(a_idle_frame, rsp.valid && !rsp.xfer_start |-> rsp.opcode == '0 && rsp.tx_len == '0 && rsp.rx_len == '0, "frame fields set without a transfer")
    `ASSERT_NEVER(a_accept_frame, rsp.valid && rsp.accepted && !rsp.xfer_start, "accepted request issued no frame")
    `ASSERT_NEVER(a_ok_done, rsp.valid && rsp.done_ok && !rsp.done_res, "success reported without completion")

endmodule

// File: test/sfcs_frame_checker.sv
// ----------------------------------------------------------------------------
// SPI flash command sequencer checker
// Watches the event and result channels, predicts each result beat from the
// event beats taken by the sequencer, and compares every field in order.
// ----------------------------------------------------------------------------
module sfcs_frame_checker #(
    parameter int unsigned SECTOR_BYTES = 4096,
    parameter int unsigned FLASH_BYTES  = 262144
) (
    input  logic clk,
    input  logic rst_n,
    sfcs_req_if  req,
    sfcs_rsp_if  rsp,
    output int   mismatches,
    output int   pending,
    output int   results_seen,
    output int   ops_ok,
    output int   ops_failed,
    output int   refused
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SECTOR_COUNT = FLASH_BYTES / SECTOR_BYTES;

    sfcs_pkg::phase_t                      cur_phase;
    logic [sfcs_pkg::BYTE_W-1:0]           last_op;
    logic                                  unlocked;
    logic [sfcs_pkg::SECTOR_W-1:0]         prog_sector;
    logic [sfcs_pkg::BYTE_W-1:0]           prog_bytes [2];
    logic                                  wp_pin;

    sfcs_pkg::rsp_t expected_frames [$];

    function automatic logic [sfcs_pkg::ADDR_W-1:0] sector_base(
        input logic [sfcs_pkg::SECTOR_W-1:0] s
    );
        logic [31:0] a;
        a = 32'(s) * SECTOR_BYTES;
        return a[sfcs_pkg::ADDR_W-1:0];
    endfunction

    function automatic sfcs_pkg::rsp_t frame(input logic [sfcs_pkg::BYTE_W-1:0] op,
                                             input logic [sfcs_pkg::ADDR_W-1:0] addr,
                                             input logic [sfcs_pkg::TXLEN_W-1:0] tx,
                                             input logic [sfcs_pkg::BYTE_W-1:0] pa,
                                             input logic [sfcs_pkg::BYTE_W-1:0] pb,
                                             input logic [sfcs_pkg::SIZE_W-1:0] rx);
        sfcs_pkg::rsp_t r;
        r = '0;
        r.xfer_start = 1'b1;
        r.opcode = op;
        r.address = addr;
        r.tx_len = tx;
        r.payload_a = pa;
        r.payload_b = pb;
        r.rx_len = rx;
        last_op = op;
        return r;
    endfunction

    function automatic sfcs_pkg::rsp_t busy_poll();
        return frame(sfcs_pkg::OP_RDSR, '0, sfcs_pkg::TX_CMD, '0, '0,
                     sfcs_pkg::SIZE_W'(1));
    endfunction

    function automatic sfcs_pkg::rsp_t finish_op(input logic ok);
        sfcs_pkg::rsp_t r;
        r = '0;
        cur_phase = sfcs_pkg::PH_IDLE;
        r.done_res = 1'b1;
        r.done_ok = ok;
        return r;
    endfunction

    function automatic sfcs_pkg::rsp_t start_erase();
        cur_phase = sfcs_pkg::PH_ERASE;
        return frame(sfcs_pkg::OP_WREN, '0, sfcs_pkg::TX_CMD, '0, '0, '0);
    endfunction

    function automatic sfcs_pkg::rsp_t on_complete(input logic [sfcs_pkg::BYTE_W-1:0] st);
        sfcs_pkg::rsp_t r;
        r = '0;
        case (cur_phase)
            sfcs_pkg::PH_READ:
                r = finish_op(1'b1);
            sfcs_pkg::PH_UNLOCK:
                if (last_op == sfcs_pkg::OP_EWSR)
                    r = frame(sfcs_pkg::OP_WRSR, '0, sfcs_pkg::TX_CMD_BYTE, '0, '0, '0);
                else if (last_op == sfcs_pkg::OP_WRSR)
                    r = busy_poll();
                else
                begin
                    wp_pin = 1'b1;
                    if ((st & sfcs_pkg::SR_BP_MASK) == '0)
                    begin
                        unlocked = 1'b1;
                        r = start_erase();
                    end
                    else
                        r = finish_op(1'b0);
                end
            sfcs_pkg::PH_ERASE:
                if (last_op == sfcs_pkg::OP_WREN)
                    r = frame(sfcs_pkg::OP_SE, sector_base(prog_sector),
                              sfcs_pkg::TX_CMD_ADDR, '0, '0, '0);
                else if (last_op == sfcs_pkg::OP_SE)
                    r = busy_poll();
                else if (last_op == sfcs_pkg::OP_RDSR)
                begin
                    if ((st & sfcs_pkg::SR_BUSY) != '0)
                        r = busy_poll();
                    else
                    begin
                        cur_phase = sfcs_pkg::PH_WRITE;
                        r = frame(sfcs_pkg::OP_WREN, '0, sfcs_pkg::TX_CMD, '0, '0, '0);
                    end
                end
                else
                    r = finish_op(1'b0);
            sfcs_pkg::PH_WRITE:
                if (last_op == sfcs_pkg::OP_WREN)
                    r = frame(sfcs_pkg::OP_AAI, sector_base(prog_sector), sfcs_pkg::TX_AAI,
                              prog_bytes[0], prog_bytes[1], '0);
                else if (last_op == sfcs_pkg::OP_AAI)
                    r = busy_poll();
                else if (last_op == sfcs_pkg::OP_RDSR)
                begin
                    if ((st & sfcs_pkg::SR_BUSY) != '0)
                        r = busy_poll();
                    else
                        r = frame(sfcs_pkg::OP_WRDI, '0, sfcs_pkg::TX_CMD, '0, '0, '0);
                end
                else if (last_op == sfcs_pkg::OP_WRDI)
                    r = finish_op(1'b1);
                else
                    r = finish_op(1'b0);
            sfcs_pkg::PH_STAT, sfcs_pkg::PH_STAT1:
            begin
                cur_phase = sfcs_pkg::PH_IDLE;
                r.status_value = st;
            end
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic sfcs_pkg::rsp_t next_result(input sfcs_pkg::req_t ev);
        sfcs_pkg::rsp_t r;
        logic idle;
        r = '0;
        idle = (cur_phase == sfcs_pkg::PH_IDLE);
        case (ev.req_type)
            sfcs_pkg::REQ_READ:
                if (idle && 32'(ev.sector) < SECTOR_COUNT)
                begin
                    r = frame(sfcs_pkg::OP_READ, sector_base(ev.sector),
                              sfcs_pkg::TX_CMD_ADDR, '0, '0, ev.transfer_size);
                    r.accepted = 1'b1;
                    cur_phase = sfcs_pkg::PH_READ;
                end
            sfcs_pkg::REQ_WRITE:
                if (idle && 32'(ev.sector) < SECTOR_COUNT &&
                    32'(ev.transfer_size) <= SECTOR_BYTES)
                begin
                    prog_sector = ev.sector;
                    prog_bytes[0] = ev.first_byte;
                    prog_bytes[1] = ev.second_byte;
                    if (unlocked)
                        r = start_erase();
                    else
                    begin
                        wp_pin = 1'b0;
                        cur_phase = sfcs_pkg::PH_UNLOCK;
                        r = frame(sfcs_pkg::OP_EWSR, '0, sfcs_pkg::TX_CMD, '0, '0, '0);
                    end
                    r.accepted = 1'b1;
                end
            sfcs_pkg::REQ_DONE:
                r = on_complete(ev.status_byte);
            sfcs_pkg::REQ_STAT, sfcs_pkg::REQ_STAT1:
                if (idle)
                begin
                    cur_phase = (ev.req_type == sfcs_pkg::REQ_STAT) ?
                                sfcs_pkg::PH_STAT : sfcs_pkg::PH_STAT1;
                    r = frame((ev.req_type == sfcs_pkg::REQ_STAT) ?
                              sfcs_pkg::OP_RDSR : sfcs_pkg::OP_RDSR1,
                              '0, sfcs_pkg::TX_CMD, '0, '0, sfcs_pkg::SIZE_W'(1));
                    r.accepted = 1'b1;
                end
            default:
                ;
        endcase
        r.wp_asserted = wp_pin;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sfcs_pkg::req_t ev;
        sfcs_pkg::rsp_t want;
        if (!rst_n)
        begin
            cur_phase = sfcs_pkg::PH_IDLE;
            last_op = '0;
            unlocked = 1'b0;
            prog_sector = '0;
            prog_bytes[0] = '0;
            prog_bytes[1] = '0;
            wp_pin = 1'b1;
            expected_frames.delete();
            mismatches = 0;
            pending = 0;
            results_seen = 0;
            ops_ok = 0;
            ops_failed = 0;
            refused = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                ev.req_type = req.req_type;
                ev.sector = req.sector;
                ev.transfer_size = req.transfer_size;
                ev.first_byte = req.first_byte;
                ev.second_byte = req.second_byte;
                ev.status_byte = req.status_byte;
                want = next_result(ev);
                if (ev.req_type inside {sfcs_pkg::REQ_READ, sfcs_pkg::REQ_WRITE,
                                        sfcs_pkg::REQ_STAT, sfcs_pkg::REQ_STAT1} &&
                    !want.accepted)
                    refused++;
                if (want.done_res && want.done_ok)
                    ops_ok++;
                if (want.done_res && !want.done_ok)
                    ops_failed++;
                expected_frames.push_back(want);
            end
            if (rsp.valid && rsp.ready)
            begin
                results_seen++;
                if (expected_frames.size() == 0)
                begin
                    $error("result beat arrived with no event beat waiting for it");
                    mismatches++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(rsp.accepted));
                    check_field("xfer_start", 32'(want.xfer_start), 32'(rsp.xfer_start));
                    check_field("opcode", 32'(want.opcode), 32'(rsp.opcode));
                    check_field("address", 32'(want.address), 32'(rsp.address));
                    check_field("tx_len", 32'(want.tx_len), 32'(rsp.tx_len));
                    check_field("payload_a", 32'(want.payload_a), 32'(rsp.payload_a));
                    check_field("payload_b", 32'(want.payload_b), 32'(rsp.payload_b));
                    check_field("rx_len", 32'(want.rx_len), 32'(rsp.rx_len));
                    check_field("wp_asserted", 32'(want.wp_asserted), 32'(rsp.wp_asserted));
                    check_field("done_res", 32'(want.done_res), 32'(rsp.done_res));
                    check_field("done_ok", 32'(want.done_ok), 32'(rsp.done_ok));
                    check_field("status_value", 32'(want.status_value),
                                32'(rsp.status_value));
                end
            end
            pending = expected_frames.size();
        end
    end

endmodule

// File: test/spi_flash_command_sequencer_test.sv
// ----------------------------------------------------------------------------
// SPI flash command sequencer testbench
// Drives directed and random event beats into the sequencer: reads, status
// reads, writes through unlock, erase and program with busy polling, refused
// and ignored events. Both channels stall at random; a checker compares
// every result beat against its own prediction.
// ----------------------------------------------------------------------------
module spi_flash_command_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SECTOR_BYTES = 4096;
    localparam int unsigned FLASH_BYTES  = 262144;
    localparam int TOTAL_BEATS   = 1750;
    localparam int TAIL_BEATS    = 250;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic [sfcs_pkg::REQ_W-1:0] REQ_UNUSED = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    sfcs_req_if req_ch ();
    sfcs_rsp_if rsp_ch ();

    int  mismatches;
    int  pending;
    int  results_seen;
    int  ops_ok;
    int  ops_failed;
    int  refused;
    int  beats_sent = 0;
    int  stall_left = 0;
    int  cycles = 0;
    bit  tail = 1'b0;
    bit  tx_gaps_on = 1'b0;
    bit  rx_stalls_on = 1'b0;

    spi_flash_command_sequencer #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .FLASH_BYTES  (FLASH_BYTES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sfcs_frame_checker #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .FLASH_BYTES  (FLASH_BYTES)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen),
        .ops_ok       (ops_ok),
        .ops_failed   (ops_failed),
        .refused      (refused)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles without finishing", CYCLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!tail && stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!tail && rx_stalls_on && $urandom_range(0, 7) == 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    function automatic sfcs_pkg::req_t make_beat(
        input logic [sfcs_pkg::REQ_W-1:0] kind,
        input logic [sfcs_pkg::SECTOR_W-1:0] sec,
        input logic [sfcs_pkg::SIZE_W-1:0] size,
        input logic [sfcs_pkg::BYTE_W-1:0] b0,
        input logic [sfcs_pkg::BYTE_W-1:0] b1,
        input logic [sfcs_pkg::BYTE_W-1:0] st
    );
        sfcs_pkg::req_t b;
        b.req_type = kind;
        b.sector = sec;
        b.transfer_size = size;
        b.first_byte = b0;
        b.second_byte = b1;
        b.status_byte = st;
        return b;
    endfunction

    function automatic sfcs_pkg::req_t random_beat(input logic [sfcs_pkg::REQ_W-1:0] kind);
        return make_beat(kind, sfcs_pkg::SECTOR_W'($urandom), sfcs_pkg::SIZE_W'($urandom),
                         sfcs_pkg::BYTE_W'($urandom), sfcs_pkg::BYTE_W'($urandom),
                         sfcs_pkg::BYTE_W'($urandom));
    endfunction

    function automatic logic [sfcs_pkg::BYTE_W-1:0] flash_status();
        if ($urandom_range(0, 3) == 0)
            return sfcs_pkg::BYTE_W'($urandom);
        return sfcs_pkg::BYTE_W'($urandom) & ~(sfcs_pkg::SR_BUSY | sfcs_pkg::SR_BP_MASK);
    endfunction

    task automatic send_beat(input sfcs_pkg::req_t b);
        if (!tail && tx_gaps_on && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= b.req_type;
        req_ch.sector <= b.sector;
        req_ch.transfer_size <= b.transfer_size;
        req_ch.first_byte <= b.first_byte;
        req_ch.second_byte <= b.second_byte;
        req_ch.status_byte <= b.status_byte;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_done(input logic [sfcs_pkg::BYTE_W-1:0] st);
        send_beat(make_beat(sfcs_pkg::REQ_DONE, '0, '0, '0, '0, st));
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_completions(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                send_beat(random_beat(sfcs_pkg::REQ_W'($urandom_range(0, 7))));
            else
                send_beat(make_beat(sfcs_pkg::REQ_DONE, sfcs_pkg::SECTOR_W'($urandom),
                                    sfcs_pkg::SIZE_W'($urandom),
                                    sfcs_pkg::BYTE_W'($urandom),
                                    sfcs_pkg::BYTE_W'($urandom), flash_status()));
        end
    endtask

    task automatic run_op();
        sfcs_pkg::req_t b;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            b = random_beat(sfcs_pkg::REQ_WRITE);
            if ($urandom_range(0, 9) == 0)
                b.transfer_size = sfcs_pkg::SIZE_W'($urandom);
            else
                b.transfer_size = sfcs_pkg::SIZE_W'($urandom_range(0, SECTOR_BYTES));
            send_beat(b);
            send_completions(15 + $urandom_range(0, 4));
        end
        else if (pick < 65)
        begin
            send_beat(random_beat(sfcs_pkg::REQ_READ));
            send_completions(1 + ($urandom_range(0, 4) == 0));
        end
        else if (pick < 85)
        begin
            send_beat(random_beat($urandom_range(0, 1) ? sfcs_pkg::REQ_STAT :
                                                          sfcs_pkg::REQ_STAT1));
            send_completions(1 + ($urandom_range(0, 4) == 0));
        end
        else
        begin
            send_beat(random_beat(sfcs_pkg::REQ_W'($urandom_range(0, 7))));
            send_completions($urandom_range(0, 2));
        end
    endtask

    initial
    begin
        bit mid_drained;
        mid_drained = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.sector = '0;
        req_ch.transfer_size = '0;
        req_ch.first_byte = '0;
        req_ch.second_byte = '0;
        req_ch.status_byte = '0;
        rsp_ch.ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(make_beat(sfcs_pkg::REQ_STAT, '0, '0, '0, '0, '0));
        send_done(8'hFF);
        send_beat(make_beat(sfcs_pkg::REQ_STAT1, '0, '0, '0, '0, '0));
        send_done(8'h00);
        send_beat(make_beat(sfcs_pkg::REQ_READ, 6'd63, 16'hFFFF, '0, '0, '0));
        send_done(8'hFF);
        send_beat(make_beat(sfcs_pkg::REQ_WRITE, 6'd5, 16'(SECTOR_BYTES + 1), 8'h11, 8'h22,
                            '0));
        send_beat(make_beat(REQ_UNUSED, 6'd1, 16'd8, '0, '0, '0));
        send_done(8'h00);
        send_beat(make_beat(sfcs_pkg::REQ_WRITE, 6'd63, 16'(SECTOR_BYTES), 8'hFF, 8'h00,
                            '0));
        send_done(8'h00);
        send_done(8'h00);
        send_done(8'h08);
        send_beat(make_beat(sfcs_pkg::REQ_WRITE, 6'd0, 16'd0, 8'h00, 8'hFF, '0));
        send_done(8'h00);
        send_done(8'h00);
        send_beat(make_beat(sfcs_pkg::REQ_READ, 6'd2, 16'd4, '0, '0, '0));
        send_done(8'hF3);
        send_done(8'h00);
        send_done(8'h00);
        send_done(8'h01);
        send_done(8'h00);
        send_done(8'h00);
        send_done(8'h00);
        send_done(8'hFF);
        send_done(8'h00);
        send_done(8'h00);
        drain_results();

        while (beats_sent < TOTAL_BEATS)
        begin
            tail = (beats_sent >= TOTAL_BEATS - TAIL_BEATS);
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            if (!mid_drained && beats_sent >= TOTAL_BEATS / 2)
            begin
                drain_results();
                mid_drained = 1'b1;
            end
            run_op();
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d event beats and %0d result beats, %0d requests refused",
                 beats_sent, results_seen, refused);
        $display("operations finished: %0d successful, %0d failed", ops_ok, ops_failed);
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: spi_flash_command_sequencer.f
+incdir+design
design/sfcs_pkg.sv
design/sfcs_req_if.sv
design/sfcs_rsp_if.sv
design/sfcs_in_stage.sv
design/sfcs_engine.sv
design/sfcs_out_stage.sv
design/spi_flash_command_sequencer.sv
test/sfcs_frame_checker.sv
test/spi_flash_command_sequencer_test.sv
